[design/cfc_pkg.sv]
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants of the clipped frame-store compositor.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int COORD_W = 16;
  localparam int PIXEL_W = 32;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;

  localparam int XI_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YI_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WS_W = $clog2(MAX_WIDTH + 1);
  localparam int HS_W = $clog2(MAX_HEIGHT + 1);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_BLEND = 2'd1,
    REQ_READ  = 2'd2
  } req_kind_t;

  typedef struct packed {
    logic                in_bounds;
    logic [STORE_AW-1:0] addr;
  } loc_t;

endpackage

[design/cfc_ram.sv]
// ----------------------------------------------------------------------------
// cfc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/cfc_addr.sv]
// ----------------------------------------------------------------------------
// cfc_addr
// Clips a signed pixel position against the active frame and forms the
// row-major store address.
// ----------------------------------------------------------------------------
module cfc_addr
  import cfc_pkg::*;
(
  input  logic [COORD_W-1:0] pos_x,
  input  logic [COORD_W-1:0] pos_y,
  input  logic [CFG_W-1:0]   frame_width,
  input  logic [CFG_W-1:0]   frame_height,
  output loc_t               loc
);

  localparam int LIN_W = YI_W + WS_W + 1;

  logic [WS_W-1:0]  act_w;
  logic [HS_W-1:0]  act_h;
  logic             x_ok;
  logic             y_ok;
  logic [LIN_W-1:0] lin;

  always_comb begin
    act_w = (int'(frame_width) > MAX_WIDTH) ? WS_W'(MAX_WIDTH) : WS_W'(frame_width);
    act_h = (int'(frame_height) > MAX_HEIGHT) ? HS_W'(MAX_HEIGHT) : HS_W'(frame_height);
    x_ok  = !pos_x[COORD_W-1] && (int'(pos_x) < int'(act_w));
    y_ok  = !pos_y[COORD_W-1] && (int'(pos_y) < int'(act_h));
    lin   = LIN_W'(pos_y[YI_W-1:0]) * LIN_W'(act_w) + LIN_W'(pos_x[XI_W-1:0]);
    loc.in_bounds = x_ok && y_ok;
    loc.addr      = lin[STORE_AW-1:0];
  end

endmodule

[design/cfc_blend.sv]
// ----------------------------------------------------------------------------
// cfc_blend
// Source-over composite of one ARGB8888 pixel onto the stored pixel.
// ----------------------------------------------------------------------------
module cfc_blend
  import cfc_pkg::*;
(
  input  logic [PIXEL_W-1:0] src,
  input  logic [PIXEL_W-1:0] dst,
  output logic [PIXEL_W-1:0] result
);

  logic [7:0]  sa;
  logic [7:0]  inv;
  logic [15:0] ma;
  logic [8:0]  oa;
  logic [16:0] mr;
  logic [16:0] mg;
  logic [16:0] mb;

  always_comb begin
    sa  = src[31:24];
    inv = 8'hFF - sa;
    ma  = 16'(dst[31:24]) * 16'(inv);
    oa  = 9'(sa) + 9'(ma[15:8]);
    mr  = 17'(16'(src[23:16]) * 16'(sa)) + 17'(16'(dst[23:16]) * 16'(inv));
    mg  = 17'(16'(src[15:8]) * 16'(sa)) + 17'(16'(dst[15:8]) * 16'(inv));
    mb  = 17'(16'(src[7:0]) * 16'(sa)) + 17'(16'(dst[7:0]) * 16'(inv));
    if (sa == 8'h00) begin
      result = dst;
    end else if (sa == 8'hFF) begin
      result = src;
    end else begin
      result = {oa[7:0], mr[15:8], mg[15:8], mb[15:8]};
    end
  end

endmodule

[design/clipped_framebuffer_alpha_compositor.sv]
// ----------------------------------------------------------------------------
// clipped_framebuffer_alpha_compositor
// ARGB8888 frame store with clipped write, source-over blend and read access.
//
// Input words carry the access kind in in_tuser and the column, row and source
// pixel in in_tdata. Each accepted word yields exactly one output word with
// the stored or read pixel in out_tdata and the in-bounds flag in out_tuser;
// a clipped access returns zero and leaves the store alone.
// The clip and the store address are formed before the accepting edge. After
// acceptance the registered memory read comes first; then the blend, the write
// back and the load of the output register raise out_tvalid, once that register
// is free. The next word is accepted on the edge after the previous item has
// reached the output register, so words are handled one at a time, bounded by
// the single read-modify-write of the frame store.
// After reset the store is cleared one entry per cycle, over all
// MAX_WIDTH * MAX_HEIGHT (65536) entries; no input word is accepted during
// that pass, while configuration writes are taken at any time.
// When the receiver stalls, the result waits in the output register; a new
// word may still be accepted and is held before write-back until the output
// register frees up.
// ----------------------------------------------------------------------------
module clipped_framebuffer_alpha_compositor
  import cfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // pos_x, pos_y, pixel_in
  input  logic [1:0]           in_tuser,   // req_type
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [PIXEL_W-1:0]   out_tdata,  // pixel_out
  output logic [0:0]           out_tuser,  // in_bounds
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WB
  } state_t;

  state_t              state_r, state_nxt;
  logic                clr_busy_r, clr_busy_nxt;
  logic [STORE_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CFG_W-1:0]    frame_width_r, frame_width_nxt;
  logic [CFG_W-1:0]    frame_height_r, frame_height_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0]  out_pixel_r, out_pixel_nxt;
  logic                out_inb_r, out_inb_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [PIXEL_W-1:0]  src_r, src_nxt;
  loc_t                loc_r, loc_nxt;

  logic                in_acc;
  loc_t                loc;
  logic [PIXEL_W-1:0]  rd_data;
  logic [PIXEL_W-1:0]  blended;
  logic [PIXEL_W-1:0]  result;
  logic                wb_fire;
  logic                wb_write;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [PIXEL_W-1:0]  ram_wdata;

  cfc_addr u_addr (
    .pos_x        (in_tdata[15:0]),
    .pos_y        (in_tdata[31:16]),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .loc          (loc)
  );

  cfc_blend u_blend (
    .src    (src_r),
    .dst    (rd_data),
    .result (blended)
  );

  cfc_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state_r == S_RD),
    .raddr (loc_r.addr),
    .rdata (rd_data)
  );

  assign in_tready = !clr_busy_r && (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    case (kind_r)
      REQ_WRITE: result = src_r;
      REQ_BLEND: result = blended;
      default:   result = rd_data;
    endcase
  end

  assign wb_fire   = (state_r == S_WB) && (!out_valid_r || out_tready);
  assign wb_write  = wb_fire && loc_r.in_bounds && (kind_r == REQ_WRITE || kind_r == REQ_BLEND);
  assign ram_we    = clr_busy_r || wb_write;
  assign ram_waddr = clr_busy_r ? clr_addr_r : loc_r.addr;
  assign ram_wdata = clr_busy_r ? '0 : result;

  always_comb begin
    state_nxt        = state_r;
    clr_busy_nxt     = clr_busy_r;
    clr_addr_nxt     = clr_addr_r;
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    out_valid_nxt    = out_valid_r;
    out_pixel_nxt    = out_pixel_r;
    out_inb_nxt      = out_inb_r;
    kind_nxt         = kind_r;
    src_nxt          = src_r;
    loc_nxt          = loc_r;

    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + STORE_AW'(1);
      if (clr_addr_r == STORE_AW'(STORE_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt  = in_tuser;
          src_nxt   = in_tdata[63:32];
          loc_nxt   = loc;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        if (wb_fire) begin
          out_valid_nxt = 1'b1;
          out_pixel_nxt = loc_r.in_bounds ? result : '0;
          out_inb_nxt   = loc_r.in_bounds;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
    out_inb_r   <= out_inb_nxt;
    kind_r      <= kind_nxt;
    src_r       <= src_nxt;
    loc_r       <= loc_nxt;
    if (!rst_n) begin
      state_r        <= S_IDLE;
      clr_busy_r     <= 1'b1;
      clr_addr_r     <= '0;
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_busy_r     <= clr_busy_nxt;
      clr_addr_r     <= clr_addr_nxt;
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_pixel_r;
  assign out_tuser[0] = out_inb_r;

`ifndef ASSERT_OFF
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !clr_busy_r)
    else $error("input word accepted during the clearing pass");

  a_item_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RD) ##1 (state_r == S_WB))
    else $error("accepted word did not proceed to read and write-back");

  a_clipped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("clipped access returned a nonzero pixel");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (clr_busy_r || (state_r == S_WB && loc_r.in_bounds)))
    else $error("store written outside clearing or in-bounds write-back");
`endif

endmodule
